// ----- rtl/pgr_pkg.sv -----
// Package for the pinhole ray generator: shared types and constants.
// Used by every module of the block; has no dependencies of its own.
package pgr_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CFG_EYE_X      = 4'd0;
  localparam logic [3:0] CFG_EYE_Y      = 4'd1;
  localparam logic [3:0] CFG_EYE_Z      = 4'd2;
  localparam logic [3:0] CFG_RIGHT_AXIS = 4'd3;
  localparam logic [3:0] CFG_UP_AXIS    = 4'd4;
  localparam logic [3:0] CFG_VIEW_AXIS  = 4'd5;
  localparam logic [3:0] CFG_HALF_W_TAN = 4'd6;
  localparam logic [3:0] CFG_HALF_H_TAN = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [31:0] EYE_X_RST      = 32'h0000_0000;
  localparam logic [31:0] EYE_Y_RST      = 32'h0000_0000;
  localparam logic [31:0] EYE_Z_RST      = 32'h0001_0000;
  localparam logic [47:0] RIGHT_AXIS_RST = 48'h0000_0000_4000;
  localparam logic [47:0] UP_AXIS_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] VIEW_AXIS_RST  = 48'hFFFF_0000_0000;
  localparam logic [23:0] HALF_W_TAN_RST = 24'd37837;
  localparam logic [23:0] HALF_H_TAN_RST = 24'd21284;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Back pipeline: five set-up stages, square-root steps, divide set-up,
  // divide steps and the output register.
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 15;
  localparam int BACK_DEPTH = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // Unit length in Q1.14.
  localparam logic [14:0] UNIT_LEN = 15'd16384;

  // Combined vector handed from the front to the back.
  typedef struct packed {
    logic [48:0] mag_x;
    logic [48:0] mag_y;
    logic [48:0] mag_z;
    logic [2:0]  neg;
    logic        zero;
  } pgr_vec_t;

  // Scaled magnitudes and signs carried alongside the length computation.
  typedef struct packed {
    logic [29:0] a_x;
    logic [29:0] a_y;
    logic [29:0] a_z;
    logic [2:0]  neg;
    logic        zero;
  } pgr_side_t;

endpackage

// ----- rtl/pgr_front.sv -----
// Front part: accepts pixel positions and forms the combined vector.
// Depends on pgr_pkg; feeds pgr_queue.
module pgr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_pixel_x,
  input  logic signed [15:0]  in_pixel_y,
  input  logic [47:0]         right_axis,
  input  logic [47:0]         up_axis,
  input  logic [47:0]         view_axis,
  input  logic [23:0]         half_w_tan,
  input  logic [23:0]         half_h_tan,
  output logic                push_valid,
  input  logic                push_ready,
  output pgr_pkg::pgr_vec_t   push_data
);
  import pgr_pkg::*;

  logic [4:0] vld_r;
  logic       adv;

  logic signed [17:0] s_x, s_y;
  logic signed [42:0] prod_x_r, prod_y_r;
  logic [41:0]        pm_x, pm_y;
  logic [30:0]        rm_x, rm_y;
  logic signed [31:0] xx_r, yy_r;
  logic signed [47:0] pu_r [3];
  logic signed [47:0] pr_r [3];
  logic signed [31:0] pv_r [3];
  logic signed [49:0] c_r  [3];
  pgr_vec_t           vec_r;
  logic [48:0]        mag  [3];

  // The whole front moves together unless the last word waits on the queue.
  assign adv        = !vld_r[4] || push_ready;
  assign in_ready   = adv;
  assign push_valid = vld_r[4];
  assign push_data  = vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Stage 1: screen offset 2p - 1 in Q.12 times the tangent.
  assign s_x = $signed({in_pixel_x[15], in_pixel_x, 1'b0}) - 18'sd4096;
  assign s_y = $signed({in_pixel_y[15], in_pixel_y, 1'b0}) - 18'sd4096;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x_r <= 43'(s_x) * 43'($signed({1'b0, half_w_tan}));
      prod_y_r <= 43'(s_y) * 43'($signed({1'b0, half_h_tan}));
    end
  end

  // Stage 2: round to Q.16, half away from zero.
  assign pm_x = prod_x_r[42] ? 42'(-prod_x_r) : prod_x_r[41:0];
  assign pm_y = prod_y_r[42] ? 42'(-prod_y_r) : prod_y_r[41:0];
  assign rm_x = 31'((pm_x + 42'd2048) >> 12);
  assign rm_y = 31'((pm_y + 42'd2048) >> 12);

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= prod_x_r[42] ? -$signed({1'b0, rm_x}) : $signed({1'b0, rm_x});
      yy_r <= prod_y_r[42] ? -$signed({1'b0, rm_y}) : $signed({1'b0, rm_y});
    end
  end

  // Stages 3 to 5: per-axis products, their sum, then sign and magnitude.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (adv) begin
        pu_r[i] <= 48'($signed(up_axis[16*i +: 16])) * 48'(yy_r);
        pr_r[i] <= 48'($signed(right_axis[16*i +: 16])) * 48'(xx_r);
        pv_r[i] <= $signed({view_axis[16*i +: 16], 16'h0000});
        c_r[i]  <= 50'(pu_r[i]) + 50'(pr_r[i]) + 50'(pv_r[i]);
      end
    end
    assign mag[i] = c_r[i][49] ? 49'(-c_r[i]) : c_r[i][48:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r.mag_x <= mag[0];
      vec_r.mag_y <= mag[1];
      vec_r.mag_z <= mag[2];
      vec_r.neg   <= {c_r[2][49], c_r[1][49], c_r[0][49]};
      vec_r.zero  <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    end
  end

endmodule

// ----- rtl/pgr_queue.sv -----
// Short queue of combined vectors between the front and back parts.
// Depends on pgr_pkg.
module pgr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  pgr_pkg::pgr_vec_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pgr_pkg::pgr_vec_t pop_data
);
  import pgr_pkg::*;

  pgr_vec_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, rd_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- rtl/pgr_back.sv -----
// Back part: normalizes the combined vector to unit length.
// Depends on pgr_pkg; drains pgr_queue and drives the result ports.
module pgr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  pgr_pkg::pgr_vec_t  pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_degenerate
);
  import pgr_pkg::*;

  logic [BACK_DEPTH-1:0] vld_r;
  logic                  adv;

  // All stages move together; the last one is the output register.
  assign adv       = !vld_r[BACK_DEPTH-1] || out_ready;
  assign pop_ready = adv;
  assign out_valid = vld_r[BACK_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BACK_DEPTH-2:0], pop_valid};
    end
  end

  // Stage 1: find the highest nonzero group of seven bits.
  logic [48:0] any_bits;
  logic [2:0]  grp_sel;
  logic [48:0] m1_r [3];
  logic [2:0]  neg1_r, neg2_r;
  logic        zero1_r, zero2_r;
  logic [2:0]  grp_r;
  logic [6:0]  gbits_r;

  assign any_bits = pop_data.mag_x | pop_data.mag_y | pop_data.mag_z;

  always_comb begin
    grp_sel = '0;
    for (int g = 0; g < 7; g++) begin
      if (any_bits[7*g +: 7] != '0) grp_sel = 3'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r[0] <= pop_data.mag_x;
      m1_r[1] <= pop_data.mag_y;
      m1_r[2] <= pop_data.mag_z;
      neg1_r  <= pop_data.neg;
      zero1_r <= pop_data.zero;
      grp_r   <= grp_sel;
      gbits_r <= any_bits[7*grp_sel +: 7];
    end
  end

  // Stage 2: leading one position within the chosen group.
  logic [2:0]  bit_sel;
  logic [5:0]  msb_r;
  logic [48:0] m2_r [3];

  always_comb begin
    bit_sel = '0;
    for (int j = 0; j < 7; j++) begin
      if (gbits_r[j]) bit_sel = 3'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r    <= m1_r;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      msb_r   <= 6'(grp_r) * 6'd7 + 6'(bit_sel);
    end
  end

  // Stage 3: common shift that puts the largest magnitude in [2^29, 2^30).
  logic [29:0] a3 [3];
  pgr_side_t   side3_r, side4_r;

  for (genvar i = 0; i < 3; i++) begin : g_shift
    always_comb begin
      if (msb_r > 6'd29) a3[i] = 30'(m2_r[i] >> (msb_r - 6'd29));
      else               a3[i] = 30'(m2_r[i] << (6'd29 - msb_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r.a_x  <= a3[0];
      side3_r.a_y  <= a3[1];
      side3_r.a_z  <= a3[2];
      side3_r.neg  <= neg2_r;
      side3_r.zero <= zero2_r;
    end
  end

  // Stage 4: squares.
  logic [59:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= side3_r.a_x * side3_r.a_x;
      sq_r[1] <= side3_r.a_y * side3_r.a_y;
      sq_r[2] <= side3_r.a_z * side3_r.a_z;
      side4_r <= side3_r;
    end
  end

  // Stage 5 and the square-root steps: one result bit per stage.
  logic [61:0] sx_r   [SQRT_STEPS+1];
  logic [61:0] sr_r   [SQRT_STEPS+1];
  pgr_side_t   sside_r[SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r[0]    <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
      sr_r[0]    <= '0;
      sside_r[0] <= side4_r;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (62 - 2*k);
    logic [61:0] trial;
    assign trial = sr_r[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sx_r[k-1] >= trial) begin
          sx_r[k] <= sx_r[k-1] - trial;
          sr_r[k] <= (sr_r[k-1] >> 1) + BIT;
        end else begin
          sx_r[k] <= sx_r[k-1];
          sr_r[k] <= sr_r[k-1] >> 1;
        end
        sside_r[k] <= sside_r[k-1];
      end
    end
  end

  // Divide set-up: numerator a*16384 + L/2 for each axis.
  logic [45:0] dr_r   [DIV_STEPS+1][3];
  logic [14:0] dq_r   [DIV_STEPS+1][3];
  logic [30:0] dl_r   [DIV_STEPS+1];
  pgr_side_t   dside_r[DIV_STEPS+1];
  logic [30:0] len;

  assign len = sr_r[SQRT_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r[0][0] <= {2'b00, sside_r[SQRT_STEPS].a_x, 14'h0} + 46'(len >> 1);
      dr_r[0][1] <= {2'b00, sside_r[SQRT_STEPS].a_y, 14'h0} + 46'(len >> 1);
      dr_r[0][2] <= {2'b00, sside_r[SQRT_STEPS].a_z, 14'h0} + 46'(len >> 1);
      dq_r[0][0] <= '0;
      dq_r[0][1] <= '0;
      dq_r[0][2] <= '0;
      dl_r[0]    <= len;
      dside_r[0] <= sside_r[SQRT_STEPS];
    end
  end

  // Restoring division steps, one quotient bit per stage.
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - j;
    logic [45:0] dvs;
    assign dvs = 46'(dl_r[j-1]) << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          if (dr_r[j-1][i] >= dvs) begin
            dr_r[j][i] <= dr_r[j-1][i] - dvs;
            dq_r[j][i] <= dq_r[j-1][i] | (15'(1) << B);
          end else begin
            dr_r[j][i] <= dr_r[j-1][i];
            dq_r[j][i] <= dq_r[j-1][i];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dl_r[j]    <= dl_r[j-1];
        dside_r[j] <= dside_r[j-1];
      end
    end
  end

  // Output register: clamp, apply sign, zero vector override.
  logic [14:0]        dcl [3];
  logic signed [15:0] dsg [3];
  logic signed [15:0] dir_r [3];
  logic               degen_r;

  for (genvar i = 0; i < 3; i++) begin : g_out
    assign dcl[i] = (dq_r[DIV_STEPS][i] > UNIT_LEN) ? UNIT_LEN : dq_r[DIV_STEPS][i];
    assign dsg[i] = dside_r[DIV_STEPS].neg[i] ? -$signed({1'b0, dcl[i]})
                                              : $signed({1'b0, dcl[i]});
    always_ff @(posedge clk) begin
      if (adv) dir_r[i] <= dside_r[DIV_STEPS].zero ? '0 : dsg[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) degen_r <= dside_r[DIV_STEPS].zero;
  end

  assign out_dir_x      = dir_r[0];
  assign out_dir_y      = dir_r[1];
  assign out_dir_z      = dir_r[2];
  assign out_degenerate = degen_r;

  // A degenerate result carries a zero direction.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> (out_dir_x == '0) && (out_dir_y == '0)
                                    && (out_dir_z == '0))
    else $error("degenerate result with nonzero direction");

  // Each direction component stays within unit length.
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 16'sd16384) && (out_dir_x >= -16'sd16384)
               && (out_dir_y <= 16'sd16384) && (out_dir_y >= -16'sd16384)
               && (out_dir_z <= 16'sd16384) && (out_dir_z >= -16'sd16384))
    else $error("direction component beyond unit length");

  // A word taken from the queue enters the first stage.
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> vld_r[0])
    else $error("popped word lost at pipeline entry");

  // The square root of a nonzero scaled vector is at least 2^29.
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5 + SQRT_STEPS] && !dside_r[0].zero |-> dl_r[0][30:29] != 2'b00)
    else $error("vector length below normalized range");

endmodule

// ----- rtl/pinhole_ray_generator_unit.sv -----
// Pinhole camera primary ray generator: fully pipelined, one ray per cycle
// while out_ready lets the output move. A front part, a queue and a back part
// (31 square-root steps and 15 divide steps) lie between input and output.
// The queue holds 4 words between the parts.
// Synchronous active-low reset clears valid state and loads register defaults.
module pinhole_ray_generator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_origin_x,
  output logic signed [31:0] out_origin_y,
  output logic signed [31:0] out_origin_z,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_degenerate
);
  import pgr_pkg::*;

  logic [31:0] eye_x_r, eye_y_r, eye_z_r;
  logic [47:0] right_r, up_r, view_r;
  logic [23:0] hw_tan_r, hh_tan_r;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r  <= EYE_X_RST;
      eye_y_r  <= EYE_Y_RST;
      eye_z_r  <= EYE_Z_RST;
      right_r  <= RIGHT_AXIS_RST;
      up_r     <= UP_AXIS_RST;
      view_r   <= VIEW_AXIS_RST;
      hw_tan_r <= HALF_W_TAN_RST;
      hh_tan_r <= HALF_H_TAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EYE_X:      eye_x_r  <= cfg_wdata[31:0];
        CFG_EYE_Y:      eye_y_r  <= cfg_wdata[31:0];
        CFG_EYE_Z:      eye_z_r  <= cfg_wdata[31:0];
        CFG_RIGHT_AXIS: right_r  <= cfg_wdata;
        CFG_UP_AXIS:    up_r     <= cfg_wdata;
        CFG_VIEW_AXIS:  view_r   <= cfg_wdata;
        CFG_HALF_W_TAN: hw_tan_r <= cfg_wdata[23:0];
        CFG_HALF_H_TAN: hh_tan_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Origin is the eye; the user must change it only while idle; unenforced.
  assign out_origin_x = eye_x_r;
  assign out_origin_y = eye_y_r;
  assign out_origin_z = eye_z_r;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  pgr_vec_t push_data, pop_data;

  pgr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .right_axis (right_r),
    .up_axis    (up_r),
    .view_axis  (view_r),
    .half_w_tan (hw_tan_r),
    .half_h_tan (hh_tan_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pgr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dir_x      (out_dir_x),
    .out_dir_y      (out_dir_y),
    .out_dir_z      (out_dir_z),
    .out_degenerate (out_degenerate)
  );

endmodule
